// ----- hdl/dcps_pkg.sv -----
// ----------------------------------------------------------------------------
// dcps_pkg
// shared types and constants of the divisor count unit with prime sieve
// ----------------------------------------------------------------------------
package dcps_pkg;

  localparam int CFG_W             = 11;
  localparam int RESULT_W          = 8;
  localparam int SIEVE_LIMIT_RESET = 1001;
  localparam int SIEVE_LIMIT_MIN   = 2;
  localparam int RESULT_MAX        = 255;

  typedef enum logic {
    OP_BUILD = 1'b0,
    OP_COUNT = 1'b1
  } opcode_t;

  // divider handshake status
  typedef struct packed {
    logic busy;
    logic done;
  } div_status_t;

endpackage

// ----- hdl/divisor_count_with_prime_sieve_unit.sv -----
// ----------------------------------------------------------------------------
// divisor_count_with_prime_sieve_unit
// prime table build by sieve and divisor count by trial division
// ----------------------------------------------------------------------------
// usage
// - input channel in_valid/in_ready carries one item: in_opcode and in_value
// - build (OP_BUILD) sieves 0..sieve_limit (clamped to 2..PRIME_LIMIT) in the
//   flag ram, then stores the primes in ascending order in the prime ram and
//   answers with the number stored (saturated to 255)
// - count (OP_COUNT) divides out each stored prime while p*p <= remainder and
//   answers with the divisor count (saturated to 255)
// - result channel out_valid/out_ready carries one item per input item
// - cfg_we/cfg_wdata sets sieve_limit; write only while block is idle (unchecked)
// - one item at a time: in_ready is high only in the idle state
// - build clears the flags 0..lim, then for each sieve base i with i*i <= lim
//   marks its multiples from i*i, then reads each index 2..lim to collect
//   the primes; the flag ram has a single write port
// - count tries each stored prime in turn and divides with the restoring
//   divider, restarting it on the quotient after each exact division
// - the result sits in an output register; if the receiver stalls the unit
//   holds the next result until the register is free
// - reset empties the prime table (count 0) and sets sieve_limit to 1001;
//   the rams are not cleared, no entry is read before a build writes it
// ----------------------------------------------------------------------------
module divisor_count_with_prime_sieve_unit #(
  parameter int PRIME_LIMIT = 1024,
  parameter int PRIME_SLOTS = 256,
  parameter int VALUE_BITS  = 20
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic                          in_opcode,
  input  logic [VALUE_BITS-1:0]         in_value,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [dcps_pkg::RESULT_W-1:0] out_result_value,
  input  logic                          cfg_we,
  input  logic [dcps_pkg::CFG_W-1:0]    cfg_wdata
);
  import dcps_pkg::*;

  localparam int LW   = $clog2(PRIME_LIMIT + 1);   // flag address and prime width
  localparam int PSW  = $clog2(PRIME_SLOTS);       // prime ram address
  localparam int TW   = $clog2(PRIME_SLOTS + 1);   // prime count
  localparam int SQW  = 2 * LW + 2;
  localparam int CMPW = (SQW > VALUE_BITS) ? SQW : VALUE_BITS;
  localparam int CNTW = $clog2(VALUE_BITS + 2);
  localparam int AW   = RESULT_W + 1;              // running product, 256 = saturated
  localparam int PW   = AW + CNTW;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_CLR,
    ST_SRD,
    ST_SCHK,
    ST_MARK,
    ST_KRD,
    ST_KCHK,
    ST_BFIN,
    ST_CRD,
    ST_CSQ,
    ST_CCMP,
    ST_CDIV,
    ST_CFIN,
    ST_DONE
  } state_t;

  state_t                state_r, state_nxt;
  logic [CFG_W-1:0]      limit_r, limit_nxt;
  logic [LW-1:0]         lim_r, lim_nxt;
  logic [LW-1:0]         i_r, i_nxt;
  logic [SQW-1:0]        isq_r, isq_nxt;
  logic [LW:0]           j_r, j_nxt;
  logic [TW-1:0]         total_r, total_nxt;
  logic [TW-1:0]         k_r, k_nxt;
  logic [VALUE_BITS-1:0] n_r, n_nxt;
  logic [LW-1:0]         p_r, p_nxt;
  logic [2*LW-1:0]       sq_r, sq_nxt;
  logic [CNTW-1:0]       cnt_r, cnt_nxt;
  logic [AW-1:0]         ans_r, ans_nxt;
  logic [RESULT_W-1:0]   res_r, res_nxt;
  logic                  out_valid_r, out_valid_nxt;
  logic [RESULT_W-1:0]   out_data_r, out_data_nxt;

  // flag ram ports
  logic                  f_we;
  logic [LW-1:0]         f_waddr;
  logic                  f_wdata;
  logic                  f_rdata;
  // prime ram ports
  logic                  p_we;
  logic [PSW-1:0]        p_waddr;
  logic [LW-1:0]         p_rdata;
  logic [PSW-1:0]        p_raddr;
  // divider
  logic                  div_start;
  logic [VALUE_BITS-1:0] div_dividend;
  logic [VALUE_BITS-1:0] div_q;
  logic [LW-1:0]         div_rem;
  div_status_t           div_st;

  logic [SQW-1:0]        isq_step;
  logic [LW:0]           j_step;
  logic [PW-1:0]         prod;
  logic [AW:0]           ans_dbl;

  dcps_ram #(.WIDTH(1), .DEPTH(PRIME_LIMIT + 1)) u_flags (
    .clk   (clk),
    .we    (f_we),
    .waddr (f_waddr),
    .wdata (f_wdata),
    .raddr (i_r),
    .rdata (f_rdata)
  );

  dcps_ram #(.WIDTH(LW), .DEPTH(PRIME_SLOTS)) u_primes (
    .clk   (clk),
    .we    (p_we),
    .waddr (p_waddr),
    .wdata (i_r),
    .raddr (p_raddr),
    .rdata (p_rdata)
  );

  // a restart after an exact division goes on with the fresh quotient
  assign div_dividend = (state_r == ST_CDIV) ? div_q : n_r;

  dcps_div #(.DW(VALUE_BITS), .SW(LW)) u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (div_start),
    .dividend  (div_dividend),
    .divisor   (p_r),
    .quotient  (div_q),
    .remainder (div_rem),
    .status    (div_st)
  );

  // next square by (i+1)^2 = i^2 + 2i + 1, no multiplier in the sieve
  assign isq_step = isq_r + SQW'({i_r, 1'b1});
  assign j_step   = j_r + (LW+1)'(i_r);
  assign prod     = PW'(ans_r) * PW'(cnt_r);
  assign ans_dbl  = {ans_r, 1'b0};
  assign p_raddr  = k_r[PSW-1:0];
  assign p_waddr  = total_r[PSW-1:0];

  assign f_we    = (state_r == ST_CLR) || (state_r == ST_MARK);
  assign f_waddr = (state_r == ST_CLR) ? i_r : j_r[LW-1:0];
  assign f_wdata = (state_r == ST_CLR) ? (i_r < LW'(2)) : 1'b1;
  assign p_we    = (state_r == ST_KCHK) && !f_rdata && (total_r < TW'(PRIME_SLOTS));

  always_comb begin
    div_start = 1'b0;
    if (state_r == ST_CCMP) begin
      div_start = !((p_r < LW'(2)) || (CMPW'(sq_r) > CMPW'(n_r)));
    end else if (state_r == ST_CDIV) begin
      div_start = div_st.done && (div_rem == '0);
    end
  end

  always_comb begin
    state_nxt     = state_r;
    limit_nxt     = limit_r;
    lim_nxt       = lim_r;
    i_nxt         = i_r;
    isq_nxt       = isq_r;
    j_nxt         = j_r;
    total_nxt     = total_r;
    k_nxt         = k_r;
    n_nxt         = n_r;
    p_nxt         = p_r;
    sq_nxt        = sq_r;
    cnt_nxt       = cnt_r;
    ans_nxt       = ans_r;
    res_nxt       = res_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_data_nxt  = out_data_r;

    if (cfg_we) begin
      limit_nxt = cfg_wdata;
    end

    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          if (opcode_t'(in_opcode) == OP_BUILD) begin
            // clamp the limit into 2..PRIME_LIMIT
            if (limit_r < CFG_W'(SIEVE_LIMIT_MIN)) begin
              lim_nxt = LW'(SIEVE_LIMIT_MIN);
            end else if (32'(limit_r) > 32'(PRIME_LIMIT)) begin
              lim_nxt = LW'(PRIME_LIMIT);
            end else begin
              lim_nxt = LW'(limit_r);
            end
            i_nxt     = '0;
            state_nxt = ST_CLR;
          end else begin
            n_nxt     = in_value;
            k_nxt     = '0;
            ans_nxt   = AW'(1);
            state_nxt = (total_r == '0) ? ST_CFIN : ST_CRD;
          end
        end
      end
      ST_CLR: begin
        if (i_r == lim_r) begin
          i_nxt     = LW'(2);
          isq_nxt   = SQW'(4);
          state_nxt = (SQW'(4) > SQW'(lim_r)) ? ST_KRD : ST_SRD;
          total_nxt = '0;
        end else begin
          i_nxt = i_r + 1'b1;
        end
      end
      ST_SRD: begin
        state_nxt = ST_SCHK;
      end
      ST_SCHK: begin
        if (!f_rdata) begin
          j_nxt     = (LW+1)'(isq_r);
          state_nxt = ST_MARK;
        end else begin
          i_nxt   = i_r + 1'b1;
          isq_nxt = isq_step;
          if (isq_step > SQW'(lim_r)) begin
            i_nxt     = LW'(2);
            total_nxt = '0;
            state_nxt = ST_KRD;
          end else begin
            state_nxt = ST_SRD;
          end
        end
      end
      ST_MARK: begin
        j_nxt = j_step;
        if (j_step > (LW+1)'(lim_r)) begin
          i_nxt   = i_r + 1'b1;
          isq_nxt = isq_step;
          if (isq_step > SQW'(lim_r)) begin
            i_nxt     = LW'(2);
            total_nxt = '0;
            state_nxt = ST_KRD;
          end else begin
            state_nxt = ST_SRD;
          end
        end
      end
      ST_KRD: begin
        state_nxt = ST_KCHK;
      end
      ST_KCHK: begin
        if (p_we) begin
          total_nxt = total_r + 1'b1;
        end
        if (i_r == lim_r) begin
          state_nxt = ST_BFIN;
        end else begin
          i_nxt     = i_r + 1'b1;
          state_nxt = ST_KRD;
        end
      end
      ST_BFIN: begin
        res_nxt   = (32'(total_r) > 32'(RESULT_MAX)) ? RESULT_W'(RESULT_MAX)
                                                     : RESULT_W'(total_r);
        state_nxt = ST_DONE;
      end
      ST_CRD: begin
        state_nxt = ST_CSQ;
      end
      ST_CSQ: begin
        p_nxt     = p_rdata;
        sq_nxt    = (2*LW)'(p_rdata) * (2*LW)'(p_rdata);
        state_nxt = ST_CCMP;
      end
      ST_CCMP: begin
        cnt_nxt   = CNTW'(1);
        state_nxt = div_start ? ST_CDIV : ST_CFIN;
      end
      ST_CDIV: begin
        if (div_st.done) begin
          if (div_rem == '0) begin
            cnt_nxt = cnt_r + 1'b1;
            n_nxt   = div_q;
          end else begin
            ans_nxt = (prod > PW'(RESULT_MAX)) ? AW'(RESULT_MAX + 1) : AW'(prod);
            k_nxt   = k_r + 1'b1;
            state_nxt = ((k_r + 1'b1) >= total_r) ? ST_CFIN : ST_CRD;
          end
        end
      end
      ST_CFIN: begin
        if (n_r > VALUE_BITS'(1)) begin
          res_nxt = (ans_dbl > (AW+1)'(RESULT_MAX)) ? RESULT_W'(RESULT_MAX)
                                                    : RESULT_W'(ans_dbl);
        end else begin
          res_nxt = (ans_r > AW'(RESULT_MAX)) ? RESULT_W'(RESULT_MAX)
                                              : RESULT_W'(ans_r);
        end
        state_nxt = ST_DONE;
      end
      ST_DONE: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = res_r;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      limit_r     <= CFG_W'(SIEVE_LIMIT_RESET);
      total_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      limit_r     <= limit_nxt;
      total_r     <= total_nxt;
      out_valid_r <= out_valid_nxt;
    end
    lim_r      <= lim_nxt;
    i_r        <= i_nxt;
    isq_r      <= isq_nxt;
    j_r        <= j_nxt;
    k_r        <= k_nxt;
    n_r        <= n_nxt;
    p_r        <= p_nxt;
    sq_r       <= sq_nxt;
    cnt_r      <= cnt_nxt;
    ans_r      <= ans_nxt;
    res_r      <= res_nxt;
    out_data_r <= out_data_nxt;
  end

  assign in_ready         = (state_r == ST_IDLE);
  assign out_valid        = out_valid_r;
  assign out_result_value = out_data_r;

endmodule

// ----- hdl/dcps_ram.sv -----
// ----------------------------------------------------------------------------
// dcps_ram
// generic single write port, single read port ram with registered read
// ----------------------------------------------------------------------------
module dcps_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- hdl/dcps_div.sv -----
// ----------------------------------------------------------------------------
// dcps_div
// restoring divider, one quotient bit per cycle
// ----------------------------------------------------------------------------
module dcps_div #(
  parameter int DW = 20,
  parameter int SW = 11
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  input  logic [DW-1:0]         dividend,
  input  logic [SW-1:0]         divisor,
  output logic [DW-1:0]         quotient,
  output logic [SW-1:0]         remainder,
  output dcps_pkg::div_status_t status
);
  import dcps_pkg::*;

  localparam int CW = $clog2(DW + 1);

  logic [DW-1:0] q_r, q_nxt;
  logic [SW-1:0] rem_r, rem_nxt;
  logic [SW-1:0] d_r, d_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic          busy_r, busy_nxt;
  logic          done_r, done_nxt;
  logic [SW:0]   shifted;
  logic          ge;

  assign shifted = {rem_r, q_r[DW-1]};
  assign ge      = (shifted >= {1'b0, d_r});

  always_comb begin
    q_nxt    = q_r;
    rem_nxt  = rem_r;
    d_nxt    = d_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (start) begin
      q_nxt    = dividend;
      rem_nxt  = '0;
      d_nxt    = divisor;
      cnt_nxt  = CW'(DW);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      rem_nxt = ge ? SW'(shifted - {1'b0, d_r}) : shifted[SW-1:0];
      q_nxt   = {q_r[DW-2:0], ge};
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == CW'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    q_r   <= q_nxt;
    rem_r <= rem_nxt;
    d_r   <= d_nxt;
  end

  assign quotient    = q_r;
  assign remainder   = rem_r;
  assign status.busy = busy_r;
  assign status.done = done_r;

endmodule

// ----- hdl/dcps_checker.sv -----
// ----------------------------------------------------------------------------
// dcps_checker
// port level checks of the divisor count unit, bound to the top level
// ----------------------------------------------------------------------------
module dcps_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_valid,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic [7:0] out_result_value
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_result_value))
    else $error("result dropped or changed under stall");

  // one item at a time: busy right after an accept
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("item accepted while busy");

  // reset leaves the unit idle with no result pending
  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> in_ready && !out_valid)
    else $error("unit not idle after reset");

endmodule

bind divisor_count_with_prime_sieve_unit dcps_checker u_dcps_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .in_valid         (in_valid),
  .in_ready         (in_ready),
  .out_valid        (out_valid),
  .out_ready        (out_ready),
  .out_result_value (out_result_value)
);
